### design/ipvf_pkg.sv
// ----------------------------------------------------------------------------
// ipvf_pkg
// shared types, constants and the header field rewrite for the ipv4 fragmenter
// ----------------------------------------------------------------------------
package ipvf_pkg;

  localparam int unsigned LinkBytes  = 14;
  localparam int unsigned MaxIpBytes = 60;
  localparam int unsigned BufBytes   = LinkBytes + MaxIpBytes;
  localparam int unsigned AddrW      = $clog2(BufBytes + 1);

  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [5:0]  MIN_IHL_BYTES = 6'd20;
  localparam logic [15:0] MF_BIT        = 16'h2000;
  localparam logic [5:0]  IP_TL_HI      = 6'd2;
  localparam logic [5:0]  IP_TL_LO      = 6'd3;
  localparam logic [5:0]  IP_FO_HI      = 6'd6;
  localparam logic [5:0]  IP_FO_LO      = 6'd7;
  localparam logic [5:0]  IP_CS_HI      = 6'd10;
  localparam logic [5:0]  IP_CS_LO      = 6'd11;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_DECIDE  = 7'b0000010,
    ST_CS_RD   = 7'b0000100,
    ST_CS_ACC  = 7'b0001000,
    ST_FOLD    = 7'b0010000,
    ST_EM_RD   = 7'b0100000,
    ST_EM_PUSH = 7'b1000000
  } state_e;

  typedef enum logic [4:0] {
    PH_LINK    = 5'b00001,
    PH_IP      = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_PASS    = 5'b01000,
    PH_DRAIN   = 5'b10000
  } phase_e;

  // one byte towards the word packer
  typedef struct packed {
    logic       push;
    logic [7:0] data;
    logic       done;
    logic       frag_end;
    logic       frame_end;
  } pack_req_t;

  // ip header byte with total length, flags/offset and checksum rewritten
  function automatic logic [7:0] patch_byte(input logic [5:0]  idx,
                                            input logic [7:0]  orig,
                                            input logic [15:0] tl,
                                            input logic [15:0] fo,
                                            input logic [15:0] cs);
    logic [7:0] r;
    r = orig;
    case (idx)
      IP_TL_HI: r = tl[15:8];
      IP_TL_LO: r = tl[7:0];
      IP_FO_HI: r = fo[15:8];
      IP_FO_LO: r = fo[7:0];
      IP_CS_HI: r = cs[15:8];
      IP_CS_LO: r = cs[7:0];
      default:  r = orig;
    endcase
    return r;
  endfunction

endpackage

### design/ipvf_hdr_ram.sv
// ----------------------------------------------------------------------------
// ipvf_hdr_ram
// header byte store, one write port and one registered read port
// ----------------------------------------------------------------------------
module ipvf_hdr_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [ipvf_pkg::AddrW-1:0] waddr_i,
  input  logic [7:0]                 wdata_i,
  input  logic [ipvf_pkg::AddrW-1:0] raddr_i,
  output logic [7:0]                 rdata_o
);
  import ipvf_pkg::*;

  logic [7:0] mem [BufBytes];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/ipvf_word_pack.sv
// ----------------------------------------------------------------------------
// ipvf_word_pack
// gathers bytes into words of up to eight and holds the output register
// ----------------------------------------------------------------------------
module ipvf_word_pack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ipvf_pkg::pack_req_t req_i,
  output logic                rdy_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [71:0]         m_axis_tdata,
  output logic                m_axis_tuser,
  output logic                m_axis_tlast
);
  import ipvf_pkg::*;

  logic [63:0] acc_q, acc_d;
  logic [2:0]  slot_q, slot_d;
  logic        vld_q, vld_d;
  logic [71:0] data_q, data_d;
  logic        fe_q, fe_d, fr_q, fr_d;
  logic [63:0] acc_w;

  assign rdy_o = !vld_q;

  always_comb begin
    acc_d  = acc_q;
    slot_d = slot_q;
    vld_d  = vld_q;
    data_d = data_q;
    fe_d   = fe_q;
    fr_d   = fr_q;
    acc_w  = acc_q;
    acc_w[slot_q*8 +: 8] = req_i.data;
    if (vld_q && m_axis_tready) begin
      vld_d = 1'b0;
    end
    if (req_i.push && !vld_q) begin
      if (req_i.done || slot_q == 3'd7) begin
        data_d = {4'd0, {1'b0, slot_q} + 4'd1, acc_w};
        fe_d   = req_i.done & req_i.frag_end;
        fr_d   = req_i.done & req_i.frame_end;
        vld_d  = 1'b1;
        acc_d  = '0;
        slot_d = 3'd0;
      end else begin
        acc_d  = acc_w;
        slot_d = slot_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      slot_q <= 3'd0;
      vld_q  <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      slot_q <= slot_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    fe_q   <= fe_d;
    fr_q   <= fr_d;
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = fe_q;
  assign m_axis_tlast  = fr_q;

endmodule

### design/ipvf_fragmenter_ctrl.sv
// ----------------------------------------------------------------------------
// ipvf_fragmenter_ctrl
// per-byte sequencer: frame parsing, checksum pass and byte emission
// ----------------------------------------------------------------------------
module ipvf_fragmenter_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 in_byte_i,
  input  logic                       in_last_i,
  input  logic [13:0]                max_frame_i,
  output logic                       we_o,
  output logic [ipvf_pkg::AddrW-1:0] waddr_o,
  output logic [ipvf_pkg::AddrW-1:0] raddr_o,
  input  logic [7:0]                 rdata_i,
  output ipvf_pkg::pack_req_t        pack_o,
  input  logic                       pack_rdy_i
);
  import ipvf_pkg::*;

  localparam logic [AddrW-1:0] LinkA = AddrW'(LinkBytes);

  state_e st_q, st_d;
  phase_e ph_q, ph_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [5:0]  hb_q, hb_d;
  logic [15:0] total_q, total_d, chunk_q, chunk_d, off_q, off_d, bif_q, bif_d;
  logic [15:0] base_q, base_d, tl_q, tl_d, fw_q, fw_d;
  logic        omf_q, omf_d;
  logic [7:0]  et_hi_q, et_hi_d, byte_q, byte_d;
  logic        last_q, last_d;
  logic [AddrW-1:0] n_q, n_d, len_q, len_d, j_q, j_d;
  logic        built_q, built_d, fe_q, fe_d, fr_q, fr_d;
  logic [20:0] sum_q, sum_d;
  logic [15:0] cs_q, cs_d, tlo_q, tlo_d, foo_q, foo_d;

  // decode helpers
  logic [5:0]  idx, h_new, hb;
  logic [15:0] left, flen, pay;
  logic [16:0] off_fl, off_ch;
  logic [14:0] ovh8;
  logic [13:0] diff;
  logic        more, fend, go, extra;
  logic [AddrW-1:0] n_new;
  logic [7:0]  pb, eb;
  logic [16:0] s1;
  logic [15:0] s2;

  assign in_ready_o = (st_q == ST_IDLE);
  assign we_o    = in_valid_i && in_ready_o && (ph_q == PH_LINK || ph_q == PH_IP);
  assign waddr_o = pos_q;

  always_comb begin
    st_d = st_q;  ph_d = ph_q;  pos_d = pos_q;  hb_d = hb_q;
    total_d = total_q;  chunk_d = chunk_q;  off_d = off_q;  bif_d = bif_q;
    base_d = base_q;  tl_d = tl_q;  fw_d = fw_q;  omf_d = omf_q;
    et_hi_d = et_hi_q;  byte_d = byte_q;  last_d = last_q;
    n_d = n_q;  len_d = len_q;  j_d = j_q;  built_d = built_q;
    fe_d = fe_q;  fr_d = fr_q;  sum_d = sum_q;  cs_d = cs_q;
    tlo_d = tlo_q;  foo_d = foo_q;
    raddr_o = '0;
    pack_o  = '0;
    idx   = 6'(pos_q - LinkA);
    h_new = {byte_q[3:0], 2'b00};
    hb    = (idx == 6'd0) ? h_new : hb_q;
    left  = total_q - off_q;
    flen  = (chunk_q < left) ? chunk_q : left;
    off_fl = {1'b0, off_q} + {1'b0, flen};
    off_ch = {1'b0, off_q} + {1'b0, chunk_q};
    pay   = (tl_q > {10'd0, hb}) ? tl_q - {10'd0, hb} : 16'd0;
    ovh8  = 15'(LinkBytes) + {9'd0, hb} + 15'd8;
    diff  = max_frame_i - 14'(LinkBytes) - {8'd0, hb};
    more  = (off_ch < {1'b0, total_q}) ? 1'b1 : omf_q;
    fend  = ({bif_q + 16'd1} >= flen);
    go    = 1'b0;
    extra = 1'b0;
    n_new = '0;
    pb = patch_byte(j_q[5:0], rdata_i, tlo_q, foo_q, 16'd0);
    eb = byte_q;
    s1 = {1'b0, sum_q[15:0]} + {12'd0, sum_q[20:16]};
    s2 = s1[15:0] + {15'd0, s1[16]};

    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          byte_d = in_byte_i;
          last_d = in_last_i;
          st_d   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        built_d = 1'b0;
        fe_d    = 1'b0;
        fr_d    = 1'b0;
        unique case (ph_q)
          PH_LINK: begin
            pos_d = pos_q + 1'b1;
            if (pos_q == LinkA - 2'd2) et_hi_d = byte_q;
            if (pos_q == LinkA - 1'b1) begin
              if ({et_hi_q, byte_q} != ETH_TYPE_IPV4) begin
                go = 1'b1;  n_new = LinkA;
                fe_d = last_q;  fr_d = last_q;
                ph_d = PH_PASS;
              end else begin
                if (last_q) begin
                  go = 1'b1;  n_new = LinkA;  fe_d = 1'b1;  fr_d = 1'b1;
                end
                ph_d = PH_IP;
              end
            end else if (last_q) begin
              go = 1'b1;  n_new = pos_q + 1'b1;  fe_d = 1'b1;  fr_d = 1'b1;
            end
          end
          PH_IP: begin
            pos_d = pos_q + 1'b1;
            if (idx == IP_TL_HI) tl_d[15:8] = byte_q;
            if (idx == IP_TL_LO) tl_d[7:0]  = byte_q;
            if (idx == IP_FO_HI) fw_d[15:8] = byte_q;
            if (idx == IP_FO_LO) fw_d[7:0]  = byte_q;
            if (idx == 6'd0) hb_d = h_new;
            if (idx == 6'd0 && h_new < MIN_IHL_BYTES) begin
              go = 1'b1;  n_new = LinkA + 1'b1;
              fe_d = last_q;  fr_d = last_q;
              ph_d = PH_PASS;
            end else if ({1'b0, idx} + 7'd1 >= {1'b0, hb}) begin
              total_d = pay;
              omf_d   = fw_q[13];
              base_d  = {fw_q[12:0], 3'b000};
              chunk_d = ({1'b0, max_frame_i} >= ovh8) ? {2'd0, diff[13:3], 3'b000}
                                                      : 16'd8;
              off_d   = '0;
              bif_d   = '0;
              if (pay == 16'd0) begin
                go = 1'b1;  built_d = 1'b1;  n_new = LinkA + AddrW'(hb);
                fe_d = 1'b1;  fr_d = 1'b1;
                tlo_d = {10'd0, hb};
                foo_d = {3'd0, fw_q[12:0]} | (fw_q[13] ? MF_BIT : 16'd0);
                ph_d = PH_DRAIN;
              end else if (last_q) begin
                go = 1'b1;  n_new = LinkA + AddrW'(hb);  fe_d = 1'b1;  fr_d = 1'b1;
              end else begin
                ph_d = PH_PAYLOAD;
              end
            end else if (last_q) begin
              go = 1'b1;  n_new = pos_q + 1'b1;  fe_d = 1'b1;  fr_d = 1'b1;
            end
          end
          PH_PAYLOAD: begin
            go = 1'b1;  extra = 1'b1;
            if (bif_q == 16'd0) begin
              built_d = 1'b1;
              n_new   = LinkA + AddrW'(hb_q);
              tlo_d   = {10'd0, hb_q} + flen;
              foo_d   = {3'd0, 13'((base_q + off_q) >> 3)} | (more ? MF_BIT : 16'd0);
            end
            if (fend) begin
              off_d = off_fl[15:0];
              bif_d = '0;
              if (off_fl >= {1'b0, total_q}) begin
                fr_d = 1'b1;
                ph_d = PH_DRAIN;
              end
            end else begin
              bif_d = bif_q + 16'd1;
            end
            fe_d = fend | last_q;
            fr_d = fr_d | last_q;
          end
          PH_PASS: begin
            go = 1'b1;  extra = 1'b1;  fe_d = last_q;  fr_d = last_q;
          end
          PH_DRAIN: begin
            go = 1'b0;
          end
          default: begin
            go = 1'b0;
          end
        endcase
        if (last_q) begin
          ph_d  = PH_LINK;
          pos_d = '0;
        end
        n_d   = n_new;
        len_d = n_new + AddrW'(extra);
        j_d   = '0;
        sum_d = '0;
        if (!go) st_d = ST_IDLE;
        else if (built_d) st_d = ST_CS_RD;
        else st_d = ST_EM_RD;
      end
      ST_CS_RD: begin
        raddr_o = LinkA + j_q;
        st_d    = ST_CS_ACC;
      end
      ST_CS_ACC: begin
        sum_d = sum_q + (j_q[0] ? {13'd0, pb} : {5'd0, pb, 8'd0});
        j_d   = j_q + 1'b1;
        st_d  = (j_q + 1'b1 == AddrW'(hb_q)) ? ST_FOLD : ST_CS_RD;
      end
      ST_FOLD: begin
        cs_d = ~s2;
        j_d  = '0;
        st_d = ST_EM_RD;
      end
      ST_EM_RD: begin
        raddr_o = j_q;
        st_d    = ST_EM_PUSH;
      end
      ST_EM_PUSH: begin
        // hold the read address so the byte stays put while the packer is full
        raddr_o = j_q;
        if (j_q < n_q) begin
          eb = (built_q && j_q >= LinkA)
               ? patch_byte(6'(j_q - LinkA), rdata_i, tlo_q, foo_q, cs_q) : rdata_i;
        end
        pack_o.push      = 1'b1;
        pack_o.data      = eb;
        pack_o.done      = (j_q + 1'b1 == len_q);
        pack_o.frag_end  = fe_q;
        pack_o.frame_end = fr_q;
        if (pack_rdy_i) begin
          j_d  = j_q + 1'b1;
          st_d = (j_q + 1'b1 == len_q) ? ST_IDLE : ST_EM_RD;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      ph_q    <= PH_LINK;
      pos_q   <= '0;
      hb_q    <= '0;
      total_q <= '0;
      chunk_q <= '0;
      off_q   <= '0;
      bif_q   <= '0;
      base_q  <= '0;
      omf_q   <= 1'b0;
    end else begin
      st_q    <= st_d;
      ph_q    <= ph_d;
      pos_q   <= pos_d;
      hb_q    <= hb_d;
      total_q <= total_d;
      chunk_q <= chunk_d;
      off_q   <= off_d;
      bif_q   <= bif_d;
      base_q  <= base_d;
      omf_q   <= omf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tl_q    <= tl_d;
    fw_q    <= fw_d;
    et_hi_q <= et_hi_d;
    byte_q  <= byte_d;
    last_q  <= last_d;
    n_q     <= n_d;
    len_q   <= len_d;
    j_q     <= j_d;
    built_q <= built_d;
    fe_q    <= fe_d;
    fr_q    <= fr_d;
    sum_q   <= sum_d;
    cs_q    <= cs_d;
    tlo_q   <= tlo_d;
    foo_q   <= foo_d;
  end

endmodule

### design/ipv4_fragmenter.sv
// ----------------------------------------------------------------------------
// ipv4_fragmenter
// ethernet frame in, one byte an item; ipv4 fragments out, up to eight bytes an item
// ----------------------------------------------------------------------------
// the block takes one frame byte per input item and buffers the link header and
// ipv4 header in a small header store. non-ipv4 frames and frames with a
// header length below 20 pass through unchanged. ipv4 payload is cut into
// fragments sized from max_frame_bytes (written on the cfg channel, reset 1514),
// each one preceded by the link header and a rewritten ip header carrying new
// total length, flags/offset and checksum; bytes past the ip total length are
// dropped. the sequencer handles one input item at a time: it takes and decodes
// a byte, then emits its bytes one at a time, reading every buffered header byte
// through the one read port of the header store. a byte that opens a fragment
// first has a checksum pass that reads each ip header byte in turn; a plain
// payload or pass-through byte has none. a finished output word waits in its
// own register, so the next input item is taken while it is still pending
module ipv4_fragmenter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // in_byte
  input  logic        s_axis_tlast,  // in_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // out_word [63:0], out_bytes [67:64], zero pad
  output logic        m_axis_tuser,  // fragment_end
  output logic        m_axis_tlast,  // frame_end
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [13:0] cfg_data_i     // max_frame_bytes
);
  import ipvf_pkg::*;

  logic [13:0]      max_q;
  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [7:0]       rdata;
  pack_req_t        pack_req;
  logic             pack_rdy;

  // register write is always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= 14'd1514;
    end else if (cfg_valid_i) begin
      max_q <= cfg_data_i;
    end
  end

  // link and ip header bytes, addressed by their place in the frame
  ipvf_hdr_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // parsing, checksum pass and byte emission
  ipvf_fragmenter_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .max_frame_i (max_q),
    .we_o        (we),
    .waddr_o     (waddr),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .pack_o      (pack_req),
    .pack_rdy_i  (pack_rdy)
  );

  // output words and their register
  ipvf_word_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (pack_req),
    .rdy_o         (pack_rdy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### verif/tb_ipv4_fragmenter.sv
// ----------------------------------------------------------------------------
// tb_ipv4_fragmenter
// self-checking testbench for the ipv4 fragmenter
// ----------------------------------------------------------------------------
// ethernet frames go in one byte per item. a scoreboard class predicts the
// output words of every accepted byte and compares each output item in order.
// a short directed sequence with random header contents runs under three
// idling patterns and several max_frame_bytes settings, the extremes among them
// ----------------------------------------------------------------------------
module tb_ipv4_fragmenter;
  timeunit 1ns;
  timeprecision 1ps;
  import ipvf_pkg::*;

  // one expected output item
  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        frag_end;
    logic        frame_end;
  } frag_word_t;

  // predicts output words from accepted bytes and checks them in order
  class frag_scoreboard;
    frag_word_t  word_q[$];
    int          errors;
    int          words_seen;
    logic [7:0]  link_hdr[LinkBytes];
    logic [7:0]  ip_hdr[MaxIpBytes];
    logic [7:0]  fbuf[LinkBytes + MaxIpBytes + 1];
    int unsigned byte_pos, hdr_len, pay_total, chunk, pay_off, frag_fill, base_off;
    logic        orig_mf;
    phase_e      phase;
    int unsigned max_frame;

    function new();
      errors = 0;
      words_seen = 0;
      byte_pos = 0; hdr_len = 0; pay_total = 0; chunk = 0;
      pay_off = 0; frag_fill = 0; base_off = 0; orig_mf = 1'b0;
      phase = PH_LINK;
      max_frame = 1514;
    endfunction

    function void set_max_frame(logic [13:0] v);
      max_frame = v;
    endfunction

    function int pending();
      return word_q.size();
    endfunction

    // cut n bytes of fbuf into output words
    function void push_words(int unsigned n, logic fe, logic fre);
      int unsigned words, cnt;
      frag_word_t  w;
      words = (n + 7) / 8;
      for (int unsigned i = 0; i < words; i++) begin
        cnt = n - i * 8;
        if (cnt > 8) cnt = 8;
        w.word = '0;
        for (int unsigned k = 0; k < cnt; k++) w.word[8*k +: 8] = fbuf[i*8 + k];
        w.nbytes    = cnt[3:0];
        w.frag_end  = (i + 1 == words) && fe;
        w.frame_end = (i + 1 == words) && fre;
        word_q = {word_q, w};
      end
    endfunction

    // raw copy of the buffered header bytes
    function int unsigned copy_raw(int unsigned n);
      int unsigned i;
      for (i = 0; i < n && i < LinkBytes + MaxIpBytes; i++)
        fbuf[i] = (i < LinkBytes) ? link_hdr[i] : ip_hdr[i - LinkBytes];
      return i;
    endfunction

    // link header and rewritten ip header for one fragment
    function int unsigned make_header(int unsigned frag_len, logic more);
      logic [15:0] tl, fo;
      logic [31:0] sum;
      for (int i = 0; i < LinkBytes; i++) fbuf[i] = link_hdr[i];
      for (int i = 0; i < hdr_len; i++) fbuf[LinkBytes + i] = ip_hdr[i];
      tl = 16'(hdr_len + frag_len);
      fo = 16'(base_off + pay_off) >> 3;
      if (more) fo = fo | MF_BIT;
      fbuf[LinkBytes + IP_TL_HI] = tl[15:8];
      fbuf[LinkBytes + IP_TL_LO] = tl[7:0];
      fbuf[LinkBytes + IP_FO_HI] = fo[15:8];
      fbuf[LinkBytes + IP_FO_LO] = fo[7:0];
      fbuf[LinkBytes + IP_CS_HI] = 8'h00;
      fbuf[LinkBytes + IP_CS_LO] = 8'h00;
      sum = 0;
      for (int i = 0; i + 1 < hdr_len; i += 2)
        sum += {fbuf[LinkBytes + i], fbuf[LinkBytes + i + 1]};
      while (sum >> 16) sum = (sum & 32'hFFFF) + (sum >> 16);
      sum = ~sum & 32'hFFFF;
      fbuf[LinkBytes + IP_CS_HI] = sum[15:8];
      fbuf[LinkBytes + IP_CS_LO] = sum[7:0];
      return LinkBytes + hdr_len;
    endfunction

    // accepted input byte: work out the words it causes
    function void note_byte(logic [7:0] b, logic last);
      int unsigned pos, idx, h, ovh, flen, n;
      logic [15:0] tl, fw;
      logic        bad, more, fe, fre;
      pos = byte_pos;
      case (phase)
        PH_LINK: begin
          if (pos < LinkBytes) link_hdr[pos] = b;
          byte_pos = pos + 1;
          if (pos + 1 >= LinkBytes) begin
            if ({link_hdr[12], link_hdr[13]} != ETH_TYPE_IPV4) begin
              n = copy_raw(LinkBytes);
              push_words(n, last, last);
              phase = PH_PASS;
            end else begin
              if (last) begin
                n = copy_raw(LinkBytes);
                push_words(n, 1'b1, 1'b1);
              end
              phase = PH_IP;
            end
          end else if (last) begin
            n = copy_raw(pos + 1);
            push_words(n, 1'b1, 1'b1);
          end
        end
        PH_IP: begin
          idx = pos - LinkBytes;
          if (idx < MaxIpBytes) ip_hdr[idx] = b;
          byte_pos = pos + 1;
          bad = 1'b0;
          if (idx == 0) begin
            h = (b & 8'h0F) * 4;
            hdr_len = h & 6'h3F;
            if (h < MIN_IHL_BYTES || h > MaxIpBytes) begin
              n = copy_raw(LinkBytes + 1);
              push_words(n, last, last);
              phase = PH_PASS;
              bad = 1'b1;
            end
          end
          if (!bad) begin
            if (idx + 1 >= hdr_len) begin
              tl  = {ip_hdr[2], ip_hdr[3]};
              fw  = {ip_hdr[6], ip_hdr[7]};
              ovh = LinkBytes + hdr_len;
              pay_total = (tl > hdr_len) ? tl - hdr_len : 0;
              orig_mf   = fw[13];
              base_off  = 16'(fw << 3);
              chunk = (max_frame >= ovh + 8) ? ((max_frame - ovh) & ~32'h7) : 8;
              pay_off   = 0;
              frag_fill = 0;
              if (pay_total == 0) begin
                n = make_header(0, orig_mf);
                push_words(n, 1'b1, 1'b1);
                phase = PH_DRAIN;
              end else if (last) begin
                n = copy_raw(ovh);
                push_words(n, 1'b1, 1'b1);
              end else begin
                phase = PH_PAYLOAD;
              end
            end else if (last) begin
              n = copy_raw(LinkBytes + idx + 1);
              push_words(n, 1'b1, 1'b1);
            end
          end
        end
        PH_PAYLOAD: begin
          flen = (chunk < pay_total - pay_off) ? chunk : pay_total - pay_off;
          fre  = 1'b0;
          if (frag_fill == 0) begin
            more = (pay_off + chunk < pay_total) ? 1'b1 : orig_mf;
            n = make_header(flen, more);
          end else begin
            n = 0;
          end
          fbuf[n] = b;
          n++;
          frag_fill++;
          fe = (frag_fill >= flen);
          if (fe) begin
            pay_off   = 16'(pay_off + flen);
            frag_fill = 0;
            if (pay_off >= pay_total) begin
              fre   = 1'b1;
              phase = PH_DRAIN;
            end
          end
          push_words(n, fe | last, fre | last);
        end
        PH_PASS: begin
          fbuf[0] = b;
          push_words(1, last, last);
        end
        default: ;
      endcase
      if (last) begin
        phase    = PH_LINK;
        byte_pos = 0;
      end
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_word(logic [63:0] word, logic [3:0] nb, logic fe, logic fre);
      frag_word_t w;
      words_seen++;
      if (word_q.size() == 0) begin
        report($sformatf("unexpected word %h bytes %0d", word, nb));
        return;
      end
      w = word_q.pop_front();
      if (word !== w.word || nb !== w.nbytes || fe !== w.frag_end || fre !== w.frame_end)
        report($sformatf("word %h/%0d/%b/%b, want %h/%0d/%b/%b", word, nb, fe, fre,
                         w.word, w.nbytes, w.frag_end, w.frame_end));
    endtask
  endclass

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned SettleCycles = 400;  // settle wait after the last expected word

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // in_byte
  logic        s_axis_tlast;   // in_last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // out_word [63:0], out_bytes [67:64]
  logic        m_axis_tuser;   // fragment_end
  logic        m_axis_tlast;   // frame_end
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [13:0] cfg_data_i;     // max_frame_bytes

  frag_scoreboard sb = new();
  logic [7:0]  frame_q[$];
  int unsigned send_idle, recv_idle;
  int unsigned cycles, frames_sent, bytes_sent;

  ipv4_fragmenter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // run guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[ipv4_fragmenter] ERROR");
      $finish;
    end
  end

  // receiver back-pressure, changed on the falling edge only
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // output items are sampled on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_word(m_axis_tdata[63:0], m_axis_tdata[67:64], m_axis_tuser, m_axis_tlast);
  end

  // one byte item; entered and left at a falling edge
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    frames_sent++;
  endtask

  // wait for every expected word, then let the sequencer settle
  task automatic wait_idle();
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // register write, only when the block is idle
  task automatic write_max_frame(logic [13:0] v);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_max_frame(v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // frame with a given ethertype and random bytes, n in all
  task automatic build_raw(logic [15:0] etype, int unsigned n);
    frame_q.delete();
    for (int i = 0; i < 12; i++) frame_q = {frame_q, 8'($urandom)};
    frame_q = {frame_q, etype[15:8]};
    frame_q = {frame_q, etype[7:0]};
    while (frame_q.size() < n) frame_q = {frame_q, 8'($urandom)};
    while (frame_q.size() > n) void'(frame_q.pop_back());
  endtask

  // ipv4 frame: header fields given, the rest random, cut to n bytes in all
  task automatic build_ip(logic [3:0] ihl, logic [15:0] tl, logic [15:0] fw, int unsigned n);
    int unsigned h;
    build_raw(ETH_TYPE_IPV4, LinkBytes);
    h = (ihl * 4 < 20) ? 20 : ihl * 4;
    for (int unsigned k = 0; k < h; k++) begin
      case (k)
        0:        frame_q = {frame_q, {4'h4, ihl}};
        IP_TL_HI: frame_q = {frame_q, tl[15:8]};
        IP_TL_LO: frame_q = {frame_q, tl[7:0]};
        IP_FO_HI: frame_q = {frame_q, fw[15:8]};
        IP_FO_LO: frame_q = {frame_q, fw[7:0]};
        default:  frame_q = {frame_q, 8'($urandom)};
      endcase
    end
    while (frame_q.size() < n) frame_q = {frame_q, 8'($urandom)};
    while (frame_q.size() > n) void'(frame_q.pop_back());
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    cycles        = 0;
    frames_sent   = 0;
    bytes_sent    = 0;
    send_idle     = 28;
    recv_idle     = 87;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // sender idles often, receiver very often; smallest register
    write_max_frame(14'd82);
    // two fragments of 48 and 2 bytes, offset wraps, trailing bytes dropped
    build_ip(4'd5, 16'd70, 16'hFFFF, 86);
    send_frame();

    // receiver idles often, sender very often; random register
    send_idle = 87;
    recv_idle = 28;
    write_max_frame(14'($urandom_range(82, 16383)));
    build_raw(16'h86DD, 16);                     // not ipv4
    send_frame();
    wait_idle();                                 // sender holds off until all words are out
    build_ip(4'd3, 16'd40, 16'h0000, 16);        // header length too small
    send_frame();

    // no idling; largest register
    send_idle = 0;
    recv_idle = 0;
    write_max_frame(14'd16383);
    build_raw(ETH_TYPE_IPV4, 5);                 // ends inside the link header
    send_frame();

    wait_idle();
    $display("%0d frames, %0d bytes in, %0d words out, %0d mismatches",
             frames_sent, bytes_sent, sb.words_seen, sb.errors);
    $display("covered fragmentation with offset wrap, trailing bytes, pass-through, short ihl");
    $display("and a frame cut inside the link header, under three idling patterns");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ipv4_fragmenter] OK");
    end else begin
      $display("[ipv4_fragmenter] ERROR");
    end
    $finish;
  end

endmodule
